/* rtl/i32cf_pkg.sv */
// Shared types and constants for the 32-bit constant-fold ALU.
`default_nettype none
package i32cf_pkg;

    // Operand width and number of divider cells (one quotient bit per cell)
    localparam int DATA_W    = 32;
    localparam int DIV_CELLS = DATA_W;

    // Operation codes
    typedef enum logic [3:0] {
        OP_OR     = 4'd0,
        OP_AND    = 4'd1,
        OP_EQ     = 4'd2,
        OP_NE     = 4'd3,
        OP_LT     = 4'd4,
        OP_LE     = 4'd5,
        OP_GE     = 4'd6,
        OP_GT     = 4'd7,
        OP_ADD    = 4'd8,
        OP_SUB    = 4'd9,
        OP_MUL    = 4'd10,
        OP_DIV    = 4'd11,
        OP_MOD    = 4'd12,
        OP_ASSIGN = 4'd13,
        OP_NEG    = 4'd14,
        OP_NOT    = 4'd15
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_FOLDED     = 2'd0;
    localparam logic [1:0] ST_PROBLEM    = 2'd1;
    localparam logic [1:0] ST_NOT_FOLDED = 2'd2;

    // Data handed from one pipeline cell to the next
    typedef struct packed {
        logic              valid;
        logic              is_div;   // quotient goes to the result
        logic              is_mod;   // remainder goes to the result
        logic              neg_q;    // quotient sign
        logic              neg_r;    // remainder sign (dividend sign)
        logic [DATA_W-1:0] value;    // result of non-divide operations
        logic [1:0]        status;
        logic [DATA_W-1:0] rem;      // partial remainder
        logic [DATA_W-1:0] dq;       // dividend bits in, quotient bits out
        logic [DATA_W-1:0] dsr;      // divisor magnitude
    } t_cell;

endpackage
`default_nettype wire

/* rtl/i32cf_if.sv */
// Request and response channel interfaces of the constant-fold ALU.
`default_nettype none
interface i32cf_req_if;
    logic                           valid;
    logic                           ready;
    logic [3:0]                     operation;
    logic signed [i32cf_pkg::DATA_W-1:0] left_operand;
    logic signed [i32cf_pkg::DATA_W-1:0] right_operand;

    modport source (output valid, operation, left_operand, right_operand, input ready);
    modport sink   (input valid, operation, left_operand, right_operand, output ready);
endinterface

interface i32cf_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [i32cf_pkg::DATA_W-1:0] result_value;
    logic [1:0]                     status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

/* rtl/i32cf_prep.sv */
// Entry stage: evaluates all non-divide operations and sets up the divider.
`default_nettype none
module i32cf_prep (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [3:0]                    i_op,
    input  wire logic [i32cf_pkg::DATA_W-1:0]  i_a,
    input  wire logic [i32cf_pkg::DATA_W-1:0]  i_b,
    output i32cf_pkg::t_cell                   o_cell
);

    localparam logic [i32cf_pkg::DATA_W-1:0] ONE  = i32cf_pkg::DATA_W'(1);
    localparam logic [i32cf_pkg::DATA_W-1:0] ZERO = '0;
    localparam logic [i32cf_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(i32cf_pkg::DATA_W-1){1'b0}}};

    i32cf_pkg::t_cell                 r_cell;
    i32cf_pkg::t_cell                 n_cell;
    i32cf_pkg::t_op                   w_op;
    logic [i32cf_pkg::DATA_W-1:0]     w_prod;
    logic                             w_a_nz;
    logic                             w_b_nz;
    logic                             w_lt;
    logic                             w_eq;

    assign w_op   = i32cf_pkg::t_op'(i_op);
    assign w_prod = i_a * i_b;   // low word of the product
    assign w_a_nz = (i_a != ZERO);
    assign w_b_nz = (i_b != ZERO);
    assign w_lt   = ($signed(i_a) < $signed(i_b));
    assign w_eq   = (i_a == i_b);

    // Operation select and divider setup
    always_comb begin
        n_cell        = '0;
        n_cell.valid  = i_valid;
        n_cell.status = i32cf_pkg::ST_FOLDED;
        n_cell.neg_q  = i_a[i32cf_pkg::DATA_W-1] ^ i_b[i32cf_pkg::DATA_W-1];
        n_cell.neg_r  = i_a[i32cf_pkg::DATA_W-1];
        n_cell.dq     = i_a[i32cf_pkg::DATA_W-1] ? (ZERO - i_a) : i_a;
        n_cell.dsr    = i_b[i32cf_pkg::DATA_W-1] ? (ZERO - i_b) : i_b;
        n_cell.rem    = ZERO;
        case (w_op)
            i32cf_pkg::OP_OR:  n_cell.value = (w_a_nz || w_b_nz) ? ONE : ZERO;
            i32cf_pkg::OP_AND: n_cell.value = (w_a_nz && w_b_nz) ? ONE : ZERO;
            i32cf_pkg::OP_EQ:  n_cell.value = w_eq ? ONE : ZERO;
            i32cf_pkg::OP_NE:  n_cell.value = w_eq ? ZERO : ONE;
            i32cf_pkg::OP_LT:  n_cell.value = w_lt ? ONE : ZERO;
            i32cf_pkg::OP_LE:  n_cell.value = (w_lt || w_eq) ? ONE : ZERO;
            i32cf_pkg::OP_GE:  n_cell.value = w_lt ? ZERO : ONE;
            i32cf_pkg::OP_GT:  n_cell.value = (w_lt || w_eq) ? ZERO : ONE;
            i32cf_pkg::OP_ADD: n_cell.value = i_a + i_b;
            i32cf_pkg::OP_SUB: n_cell.value = i_a - i_b;
            i32cf_pkg::OP_MUL: n_cell.value = w_prod;
            i32cf_pkg::OP_DIV: begin
                if (w_b_nz) begin
                    n_cell.is_div = 1'b1;
                end else begin
                    n_cell.status = i32cf_pkg::ST_PROBLEM;
                end
            end
            i32cf_pkg::OP_MOD: begin
                if (w_b_nz) begin
                    n_cell.is_mod = 1'b1;
                end else begin
                    n_cell.status = i32cf_pkg::ST_PROBLEM;
                end
            end
            i32cf_pkg::OP_ASSIGN: n_cell.status = i32cf_pkg::ST_NOT_FOLDED;
            i32cf_pkg::OP_NEG: begin
                if (i_a == MIN_VAL) begin
                    n_cell.status = i32cf_pkg::ST_PROBLEM;
                end else begin
                    n_cell.value = ZERO - i_a;
                end
            end
            i32cf_pkg::OP_NOT: n_cell.value = w_a_nz ? ZERO : ONE;
            default:           n_cell.status = i32cf_pkg::ST_NOT_FOLDED;
        endcase
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

/* rtl/i32cf_div_cell.sv */
// One restoring-division cell: retires one quotient bit and passes the item on.
`default_nettype none
module i32cf_div_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire i32cf_pkg::t_cell i_cell,
    output i32cf_pkg::t_cell      o_cell
);

    localparam int W = i32cf_pkg::DATA_W;

    i32cf_pkg::t_cell   r_cell;
    i32cf_pkg::t_cell   n_cell;
    logic [W:0]         w_part;
    logic [W+1:0]       w_diff;
    logic               w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_part = {i_cell.rem, i_cell.dq[W-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, i_cell.dsr};
    assign w_ge   = ~w_diff[W+1];

    always_comb begin
        n_cell     = i_cell;
        n_cell.rem = w_ge ? w_diff[W-1:0] : w_part[W-1:0];
        n_cell.dq  = {i_cell.dq[W-2:0], w_ge};
    end

    // Cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

/* rtl/i32cf_out_fifo.sv */
// Two-entry output buffer that decouples the pipeline from the response channel.
`default_nettype none
module i32cf_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [i32cf_pkg::DATA_W-1:0]  i_value,
    input  wire logic [1:0]                    i_status,
    output logic                               o_space,
    i32cf_rsp_if.source                        o_rsp
);

    logic [i32cf_pkg::DATA_W-1:0] r_value [2];
    logic [1:0]                   r_status [2];
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [1:0]                   r_count;
    logic                         w_pop;

    assign w_pop   = o_rsp.valid && o_rsp.ready;
    assign o_space = (r_count != 2'd2);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_value[r_wr_ptr]  <= i_value;
            r_status[r_wr_ptr] <= i_status;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rsp.valid        = (r_count != 2'd0);
    assign o_rsp.result_value = r_value[r_rd_ptr];
    assign o_rsp.status       = r_status[r_rd_ptr];

endmodule
`default_nettype wire

/* rtl/int32_constant_fold_alu_core.sv */
// Pipeline: request acceptance to response valid passes the entry stage,
//   32 division cells at one quotient bit each, and the output buffer.
// Throughput: one request per cycle; the cell chain advances whenever the
//   two-entry output buffer has room, so requests stall only when it is full.
// Reset: synchronous, active low; clears the stage valid bits and empties
//   the output buffer.
`default_nettype none
module int32_constant_fold_alu_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    i32cf_req_if.sink    i_req,
    i32cf_rsp_if.source  o_rsp
);

    localparam int W = i32cf_pkg::DATA_W;
    localparam int N = i32cf_pkg::DIV_CELLS;

    i32cf_pkg::t_cell   w_chain [N+1];
    logic               w_en;
    logic               w_space;
    logic [W-1:0]       w_value;
    i32cf_pkg::t_cell   w_last;

    // Whole chain moves while the output buffer can take an item
    assign w_en        = w_space;
    assign i_req.ready = w_space;

    i32cf_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_req.valid),
        .i_op    (i_req.operation),
        .i_a     (i_req.left_operand),
        .i_b     (i_req.right_operand),
        .o_cell  (w_chain[0])
    );

    // Division cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        i32cf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[N];

    // Sign fix-up of quotient or remainder
    always_comb begin
        if (w_last.is_div) begin
            w_value = w_last.neg_q ? (W'(0) - w_last.dq) : w_last.dq;
        end else if (w_last.is_mod) begin
            w_value = w_last.neg_r ? (W'(0) - w_last.rem) : w_last.rem;
        end else begin
            w_value = w_last.value;
        end
    end

    i32cf_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_en && w_last.valid),
        .i_value  (w_value),
        .i_status (w_last.status),
        .o_space  (w_space),
        .o_rsp    (o_rsp)
    );

endmodule
`default_nettype wire
